// ===== hw/rtl/llhm_pkg.sv =====
// ----------------------------------------------------------------------------
// llhm_pkg
// shared codes, field widths and register reset values of the link latency
// health monitor
// ----------------------------------------------------------------------------
package llhm_pkg;

  localparam int LAT_W    = 24;
  localparam int PCT_W    = 7;
  localparam int LIMIT_W  = 8;
  localparam int STREAK_W = 16;
  localparam int TOTAL_W  = 32;
  localparam int IDX_W    = 6;
  localparam int CFG_IDX_W = 3;

  // health codes
  localparam logic [1:0] HEALTH_OK      = 2'd0;
  localparam logic [1:0] HEALTH_WARN    = 2'd1;
  localparam logic [1:0] HEALTH_CRIT    = 2'd2;
  localparam logic [1:0] HEALTH_UNKNOWN = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAT_WARN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_CRIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_WARN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_CRIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIM  = 3'd4;

  // register reset values
  localparam logic [LAT_W-1:0]   RST_LAT_WARN  = 24'd100000;
  localparam logic [LAT_W-1:0]   RST_LAT_CRIT  = 24'd500000;
  localparam logic [PCT_W-1:0]   RST_LOSS_WARN = 7'd5;
  localparam logic [PCT_W-1:0]   RST_LOSS_CRIT = 7'd20;
  localparam logic [LIMIT_W-1:0] RST_FAIL_LIM  = 8'd3;

  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  // divider handshake
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== hw/rtl/llhm_ram.sv =====
// ----------------------------------------------------------------------------
// llhm_ram
// single write, single read synchronous memory with registered read data
// ----------------------------------------------------------------------------
module llhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/llhm_div.sv =====
// ----------------------------------------------------------------------------
// llhm_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module llhm_div #(
  parameter int DW = 34,
  parameter int VW = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DW-1:0]          dividend,
  input  logic [VW-1:0]          divisor,
  output llhm_pkg::div_status_t  status,
  output logic [DW-1:0]          quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] count;
  logic          busy;
  logic          done;
  logic [VW:0]   shifted;
  logic          fits;

  assign shifted = {rem, quotient[DW-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(DW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= VW'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[VW-1:0];
      end
      quotient <= {quotient[DW-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== hw/rtl/link_latency_health_monitor_top.sv =====
// ----------------------------------------------------------------------------
// link_latency_health_monitor_top
// per-server probe statistics and health grading
// ----------------------------------------------------------------------------
// usage:
//   probe channel: in_valid / in_stall with server_index, probe_ok, latency_us.
//   result channel: out_valid / out_stall with health, health_changed and the
//   server's running statistics, one result per probe on a known server.
//   register channel: cfg_valid / cfg_ready with cfg_index and cfg_data, always
//   ready; write only while no probe is in flight.
// sequencing: one probe at a time; the next request is taken only once the
//   previous probe has written its result, and the result waits on the
//   shift-subtract divider for the average, which works through all DW =
//   24 + clog2(WINDOW) bits of the window sum (34 with the default window).
// a probe on a server index at or above SERVERS is taken and dropped.
// reset: registers take their defaults, every server record reads as cleared
//   with unknown health through a per-server valid bit; sample slots are never
//   read before written so they need no clearing.
// receiver stall: the result register holds, and a finished probe waits in the
//   last step until the result register is free; the probe side stays stalled.
// ----------------------------------------------------------------------------
module link_latency_health_monitor_top #(
  parameter int SERVERS = 64,
  parameter int WINDOW  = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // probe requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  server_index,
  input  logic        probe_ok,
  input  logic [23:0] latency_us,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  health,
  output logic        health_changed,
  output logic [23:0] avg_latency_us,
  output logic [23:0] min_latency_us,
  output logic [23:0] max_latency_us,
  output logic [15:0] fail_run,
  output logic [31:0] checks_total,
  output logic [31:0] failures_total,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int LAT_W  = llhm_pkg::LAT_W;
  localparam int TOT_W  = llhm_pkg::TOTAL_W;
  localparam int STK_W  = llhm_pkg::STREAK_W;
  localparam int SRV_W  = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = LAT_W + $clog2(WINDOW);
  localparam int SMP_N  = SERVERS * WINDOW;
  localparam int SMP_AW = (SMP_N > 1) ? $clog2(SMP_N) : 1;
  localparam int SMP_W  = LAT_W + 1;
  localparam int PRD_W  = TOT_W + llhm_pkg::PCT_W;

  // per-server record
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] fill;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] ok_cnt;
    logic [LAT_W-1:0] avg;
    logic [LAT_W-1:0] min_lat;
    logic             min_seen;
    logic [LAT_W-1:0] max_lat;
    logic [STK_W-1:0] streak;
    logic [TOT_W-1:0] checks;
    logic [TOT_W-1:0] fails;
    logic [1:0]       last;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RREC = 3'd1;
  localparam logic [2:0] S_RSMP = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;

  // configuration registers
  logic [LAT_W-1:0]                 lat_warn;
  logic [LAT_W-1:0]                 lat_crit;
  logic [llhm_pkg::PCT_W-1:0]       loss_warn;
  logic [llhm_pkg::PCT_W-1:0]       loss_crit;
  logic [llhm_pkg::LIMIT_W-1:0]     fail_lim;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_warn  <= llhm_pkg::RST_LAT_WARN;
      lat_crit  <= llhm_pkg::RST_LAT_CRIT;
      loss_warn <= llhm_pkg::RST_LOSS_WARN;
      loss_crit <= llhm_pkg::RST_LOSS_CRIT;
      fail_lim  <= llhm_pkg::RST_FAIL_LIM;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        llhm_pkg::REG_LAT_WARN:  lat_warn  <= cfg_data;
        llhm_pkg::REG_LAT_CRIT:  lat_crit  <= cfg_data;
        llhm_pkg::REG_LOSS_WARN: loss_warn <= cfg_data[llhm_pkg::PCT_W-1:0];
        llhm_pkg::REG_LOSS_CRIT: loss_crit <= cfg_data[llhm_pkg::PCT_W-1:0];
        llhm_pkg::REG_FAIL_LIM:  fail_lim  <= cfg_data[llhm_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // probe capture
  logic             in_take;
  logic             idx_in_range;
  logic [SRV_W-1:0] idx;
  logic             ok;
  logic [LAT_W-1:0] lat;

  assign in_stall     = (state != S_IDLE);
  assign in_take      = in_valid && !in_stall;
  assign idx_in_range = 32'(server_index) < SERVERS;

  always_ff @(posedge clk) begin
    if (in_take) begin
      idx <= SRV_W'(server_index);
      ok  <= probe_ok;
      lat <= probe_ok ? latency_us : '0;
    end
  end

  // record memory with per-server valid bits standing in for the reset value
  logic [SERVERS-1:0] rec_vld;
  logic               rec_vld_rd;
  logic               rec_we;
  logic [REC_W-1:0]   rec_rd_data;
  rec_t               rec_rst;
  rec_t               rec;
  rec_t               upd;

  always_comb begin
    rec_rst      = '0;
    rec_rst.last = llhm_pkg::HEALTH_UNKNOWN;
  end

  llhm_ram #(.WIDTH(REC_W), .DEPTH(SERVERS), .AW(SRV_W)) u_rec_ram (
    .clk     (clk),
    .wr_en   (rec_we),
    .wr_addr (idx),
    .wr_data (REC_W'(upd)),
    .rd_addr (SRV_W'(server_index)),
    .rd_data (rec_rd_data)
  );

  always_ff @(posedge clk) begin
    rec_vld_rd <= rec_vld[SRV_W'(server_index)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_vld <= '0;
    end else if (rec_we) begin
      rec_vld[idx] <= 1'b1;
    end
  end

  // sample memory, one slot per server and window position
  logic              smp_we;
  logic [SMP_AW-1:0] smp_rd_addr;
  logic [SMP_AW-1:0] smp_wr_addr;
  logic [SMP_W-1:0]  smp_rd_data;
  rec_t              rec_cur;

  assign rec_cur     = rec_vld_rd ? rec_t'(rec_rd_data) : rec_rst;
  assign smp_rd_addr = SMP_AW'(idx) * SMP_AW'(WINDOW) + SMP_AW'(rec_cur.pos);
  assign smp_wr_addr = SMP_AW'(idx) * SMP_AW'(WINDOW) + SMP_AW'(rec.pos);
  assign smp_we      = (state == S_RSMP);

  llhm_ram #(.WIDTH(SMP_W), .DEPTH(SMP_N), .AW(SMP_AW)) u_smp_ram (
    .clk     (clk),
    .wr_en   (smp_we),
    .wr_addr (smp_wr_addr),
    .wr_data ({ok, lat}),
    .rd_addr (smp_rd_addr),
    .rd_data (smp_rd_data)
  );

  // record update once the evicted sample is known
  logic             full;
  logic             evict;
  logic [SUM_W-1:0] sum_less;
  logic [CNT_W-1:0] cnt_less;
  rec_t             rec_next;

  assign full  = rec.fill >= CNT_W'(WINDOW);
  assign evict = full && smp_rd_data[LAT_W];

  always_comb begin
    rec_next = rec;
    sum_less = evict ? rec.sum - SUM_W'(smp_rd_data[LAT_W-1:0]) : rec.sum;
    cnt_less = evict ? rec.ok_cnt - 1'b1 : rec.ok_cnt;
    if (!full) begin
      rec_next.fill = rec.fill + 1'b1;
    end
    rec_next.sum    = ok ? sum_less + SUM_W'(lat) : sum_less;
    rec_next.ok_cnt = ok ? cnt_less + 1'b1 : cnt_less;
    rec_next.pos    = (32'(rec.pos) + 1 >= WINDOW) ? '0 : rec.pos + 1'b1;
    if (rec.checks != '1) begin
      rec_next.checks = rec.checks + 1'b1;
    end
    if (ok) begin
      rec_next.streak = '0;
      if (!rec.min_seen || lat < rec.min_lat) begin
        rec_next.min_lat  = lat;
        rec_next.min_seen = 1'b1;
      end
      if (lat > rec.max_lat) begin
        rec_next.max_lat = lat;
      end
    end else begin
      if (rec.streak != '1) begin
        rec_next.streak = rec.streak + 1'b1;
      end
      if (rec.fails != '1) begin
        rec_next.fails = rec.fails + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_RREC:  rec <= rec_cur;
      S_RSMP:  rec <= rec_next;
      default: ;
    endcase
  end

  // loss products, each registered
  logic [PRD_W-1:0] loss_x100;
  logic [PRD_W-1:0] crit_x_checks;
  logic [PRD_W-1:0] warn_x_checks;

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      loss_x100     <= PRD_W'(rec.fails) * PRD_W'(llhm_pkg::PCT_SCALE);
      crit_x_checks <= PRD_W'(loss_crit) * PRD_W'(rec.checks);
      warn_x_checks <= PRD_W'(loss_warn) * PRD_W'(rec.checks);
    end
  end

  // window average
  llhm_pkg::div_status_t div_st;
  logic [SUM_W-1:0]      quot;

  llhm_div #(.DW(SUM_W), .VW(CNT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_MUL),
    .dividend (rec.sum),
    .divisor  (rec.ok_cnt),
    .status   (div_st),
    .quotient (quot)
  );

  // grading and write-back
  logic             fin_go;
  logic [1:0]       grade;
  logic             changed;
  logic [LAT_W-1:0] avg_new;

  assign fin_go  = (state == S_FIN) && (!out_valid || !out_stall);
  assign rec_we  = fin_go;
  assign avg_new = (rec.ok_cnt != '0) ? quot[LAT_W-1:0] : rec.avg;

  always_comb begin
    priority if (32'(rec.streak) >= 32'(fail_lim)) begin
      grade = llhm_pkg::HEALTH_CRIT;
    end else if (loss_x100 >= crit_x_checks) begin
      grade = llhm_pkg::HEALTH_CRIT;
    end else if (loss_x100 >= warn_x_checks) begin
      grade = llhm_pkg::HEALTH_WARN;
    end else if (avg_new >= lat_crit) begin
      grade = llhm_pkg::HEALTH_CRIT;
    end else if (avg_new >= lat_warn) begin
      grade = llhm_pkg::HEALTH_WARN;
    end else begin
      grade = llhm_pkg::HEALTH_OK;
    end
    changed = (rec.last != llhm_pkg::HEALTH_UNKNOWN) && (rec.last != grade);
    upd      = rec;
    upd.avg  = avg_new;
    upd.last = grade;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_take && idx_in_range) state <= S_RREC;
        S_RREC: state <= S_RSMP;
        S_RSMP: state <= S_MUL;
        S_MUL:  state <= S_DIV;
        S_DIV:  if (div_st.done) state <= S_FIN;
        S_FIN:  if (fin_go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      health         <= grade;
      health_changed <= changed;
      avg_latency_us <= avg_new;
      min_latency_us <= rec.min_lat;
      max_latency_us <= rec.max_lat;
      fail_run       <= rec.streak;
      checks_total   <= rec.checks;
      failures_total <= rec.fails;
    end
  end

  // checks
  a_fin_loads_result: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> out_valid)
    else $error("finished probe did not raise a result");

  a_result_graded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> health != llhm_pkg::HEALTH_UNKNOWN)
    else $error("result carries unknown health");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_st.busy |-> state == S_DIV)
    else $error("divider busy outside divide step");

  a_div_done_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && div_st.done |=> state == S_FIN)
    else $error("divide step did not hand over to write-back");

endmodule

// ===== sim/link_latency_health_monitor_top_test.sv =====
// ----------------------------------------------------------------------------
// link_latency_health_monitor_top_test
// self-checking test of the link latency health monitor: probe requests are
// sent under random idling, an in-bench model of every server record predicts
// each result, and the results are compared field by field in arrival order
// ----------------------------------------------------------------------------
module link_latency_health_monitor_top_test;

  localparam int NSRV   = 64;
  localparam int WIN    = 1024;
  localparam int SETTLE = 60;     // pause after the last result, longer than one probe takes
  localparam int STUCK  = 20000;  // cycles without any handshake before giving up

  // expected result of one probe
  typedef struct packed {
    logic [1:0]                    health;
    logic                          changed;
    logic [llhm_pkg::LAT_W-1:0]    avg;
    logic [llhm_pkg::LAT_W-1:0]    lo;
    logic [llhm_pkg::LAT_W-1:0]    hi;
    logic [llhm_pkg::STREAK_W-1:0] streak;
    logic [llhm_pkg::TOTAL_W-1:0]  checks;
    logic [llhm_pkg::TOTAL_W-1:0]  fails;
  } probe_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [5:0]  server_index = '0;
  logic        probe_ok = 1'b0;
  logic [23:0] latency_us = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  health;
  logic        health_changed;
  logic [23:0] avg_latency_us;
  logic [23:0] min_latency_us;
  logic [23:0] max_latency_us;
  logic [15:0] fail_run;
  logic [31:0] checks_total;
  logic [31:0] failures_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  link_latency_health_monitor_top DUT (.*);

  // clock, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // model of the block: thresholds and one record per server
  // ---------------------------------------------------------------------------
  logic [llhm_pkg::LAT_W-1:0]   lat_warn_thr, lat_crit_thr;
  logic [llhm_pkg::PCT_W-1:0]   loss_warn_thr, loss_crit_thr;
  logic [llhm_pkg::LIMIT_W-1:0] streak_limit;

  logic [24:0]                   ring [NSRV][WIN];   // ok bit above the latency
  int unsigned                   ring_pos  [NSRV];
  int unsigned                   ring_fill [NSRV];
  logic [63:0]                   ring_sum  [NSRV];
  int unsigned                   ring_oks  [NSRV];
  logic [llhm_pkg::LAT_W-1:0]    mean_lat  [NSRV];
  logic [llhm_pkg::LAT_W-1:0]    low_lat   [NSRV];
  logic                          low_valid [NSRV];
  logic [llhm_pkg::LAT_W-1:0]    high_lat  [NSRV];
  logic [llhm_pkg::STREAK_W-1:0] streak    [NSRV];
  logic [llhm_pkg::TOTAL_W-1:0]  probes    [NSRV];
  logic [llhm_pkg::TOTAL_W-1:0]  misses    [NSRV];
  logic [1:0]                    prev_health [NSRV];

  probe_result_t pending_results [$];

  // test control
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_off = 0;       // long receiver stall, counted in cycles
  int unsigned errors = 0;
  int unsigned probes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned wraps_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned health_hits [4];

  task automatic clear_model();
    lat_warn_thr  = llhm_pkg::RST_LAT_WARN;
    lat_crit_thr  = llhm_pkg::RST_LAT_CRIT;
    loss_warn_thr = llhm_pkg::RST_LOSS_WARN;
    loss_crit_thr = llhm_pkg::RST_LOSS_CRIT;
    streak_limit  = llhm_pkg::RST_FAIL_LIM;
    for (int s = 0; s < NSRV; s++) begin
      ring_pos[s] = 0; ring_fill[s] = 0; ring_sum[s] = '0; ring_oks[s] = 0;
      mean_lat[s] = '0; low_lat[s] = '0; low_valid[s] = 1'b0; high_lat[s] = '0;
      streak[s] = '0; probes[s] = '0; misses[s] = '0;
      prev_health[s] = llhm_pkg::HEALTH_UNKNOWN;
    end
  endtask

  // grade a server after its record has been updated
  function automatic logic [1:0] grade_server(int s);
    logic [63:0] loss_x100;
    logic [63:0] checks;
    loss_x100 = 64'(misses[s]) * 64'd100;
    checks    = 64'(probes[s]);
    if (streak[s] >= 16'(streak_limit))           return llhm_pkg::HEALTH_CRIT;
    if (loss_x100 >= 64'(loss_crit_thr) * checks) return llhm_pkg::HEALTH_CRIT;
    if (loss_x100 >= 64'(loss_warn_thr) * checks) return llhm_pkg::HEALTH_WARN;
    if (mean_lat[s] >= lat_crit_thr)              return llhm_pkg::HEALTH_CRIT;
    if (mean_lat[s] >= lat_warn_thr)              return llhm_pkg::HEALTH_WARN;
    return llhm_pkg::HEALTH_OK;
  endfunction

  // update one server record with an accepted probe and queue its result
  task automatic record_probe(logic [5:0] idx, logic ok, logic [23:0] lat_in);
    int s;
    int unsigned p;
    logic [24:0] old;
    logic [23:0] lat;
    probe_result_t r;
    s = idx;
    lat = ok ? lat_in : '0;
    p = ring_pos[s] % WIN;
    // full window: drop the sample being overwritten
    if (ring_fill[s] >= WIN) begin
      old = ring[s][p];
      wraps_seen++;
      if (old[24]) begin
        ring_sum[s] -= 64'(old[23:0]);
        ring_oks[s]--;
      end
    end else begin
      ring_fill[s]++;
    end
    ring[s][p] = {ok, lat};
    if (ok) begin
      ring_sum[s] += 64'(lat);
      ring_oks[s]++;
    end
    ring_pos[s] = (p + 1) % WIN;

    if (probes[s] != '1) probes[s]++;
    if (ok) begin
      streak[s] = '0;
      if (!low_valid[s] || lat < low_lat[s]) begin
        low_lat[s] = lat;
        low_valid[s] = 1'b1;
      end
      if (lat > high_lat[s]) high_lat[s] = lat;
    end else begin
      if (streak[s] != '1) streak[s]++;
      if (misses[s] != '1) misses[s]++;
    end
    // no success in window keeps the previous average
    if (ring_oks[s] != 0) mean_lat[s] = 24'(ring_sum[s] / 64'(ring_oks[s]));

    r.health  = grade_server(s);
    r.changed = (prev_health[s] != llhm_pkg::HEALTH_UNKNOWN) &&
                (prev_health[s] != r.health);
    prev_health[s] = r.health;
    r.avg = mean_lat[s];
    r.lo = low_lat[s];
    r.hi = high_lat[s];
    r.streak = streak[s];
    r.checks = probes[s];
    r.fails = misses[s];
    health_hits[r.health]++;
    pending_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // probe sender: random idle before each request, valid held until taken
  // ---------------------------------------------------------------------------
  task automatic send_probe(logic [5:0] idx, logic ok, logic [23:0] lat);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    server_index <= idx;
    probe_ok     <= ok;
    latency_us   <= lat;
    // values read right after the edge are the ones the block sampled
    do @(posedge clk); while (in_stall);
    probes_sent++;
    record_probe(idx, ok, lat);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender pause until every expected result is back, then let the block settle
  task automatic wait_quiet();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write, only while nothing is in flight
  task automatic write_reg(logic [2:0] idx, logic [23:0] value);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      llhm_pkg::REG_LAT_WARN:  lat_warn_thr  = value;
      llhm_pkg::REG_LAT_CRIT:  lat_crit_thr  = value;
      llhm_pkg::REG_LOSS_WARN: loss_warn_thr = value[llhm_pkg::PCT_W-1:0];
      llhm_pkg::REG_LOSS_CRIT: loss_crit_thr = value[llhm_pkg::PCT_W-1:0];
      llhm_pkg::REG_FAIL_LIM:  streak_limit  = value[llhm_pkg::LIMIT_W-1:0];
      default: ;  // unmapped index is ignored
    endcase
  endtask

  function automatic logic [23:0] rand_latency();
    case ($urandom_range(5))
      0:       return 24'($urandom);                 // anywhere in the range
      1:       return 24'($urandom_range(0, 2000));
      default: return 24'($urandom_range(0, 900000));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stall, or a long hold-off when one is requested
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // result checker: compare with the oldest expectation
  always @(posedge clk) begin
    probe_result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (health != e.health) begin
          $error("health expected %0d got %0d", e.health, health); errors++;
        end
        if (health_changed != e.changed) begin
          $error("health_changed expected %0d got %0d", e.changed, health_changed);
          errors++;
        end
        if (avg_latency_us != e.avg) begin
          $error("avg_latency_us expected %0d got %0d", e.avg, avg_latency_us); errors++;
        end
        if (min_latency_us != e.lo) begin
          $error("min_latency_us expected %0d got %0d", e.lo, min_latency_us); errors++;
        end
        if (max_latency_us != e.hi) begin
          $error("max_latency_us expected %0d got %0d", e.hi, max_latency_us); errors++;
        end
        if (fail_run != e.streak) begin
          $error("fail_run expected %0d got %0d", e.streak, fail_run); errors++;
        end
        if (checks_total != e.checks) begin
          $error("checks_total expected %0d got %0d", e.checks, checks_total); errors++;
        end
        if (failures_total != e.fails) begin
          $error("failures_total expected %0d got %0d", e.fails, failures_total);
          errors++;
        end
      end
    end
  end

  // watchdog: any handshake restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STUCK) begin
      $display("watchdog: no handshake for %0d cycles", STUCK);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, failure limit, loss and latency grading at reset thresholds
  task automatic test_directed();
    send_probe(6'd0, 1'b1, 24'd0);             // first sample, zero latency
    send_probe(6'd0, 1'b1, 24'hFFFFFF);        // largest latency
    send_probe(6'd0, 1'b0, 24'hFFFFFF);        // failed, latency ignored
    send_probe(6'd0, 1'b0, 24'd0);
    send_probe(6'd0, 1'b0, 24'h5A5A5A);        // failure run reaches the limit
    send_probe(6'd0, 1'b1, 24'd1);             // run broken
    send_probe(6'd63, 1'b0, 24'hA5A5A5);       // failure first, no success yet
    send_probe(6'd63, 1'b1, 24'd99999);        // just below warning
    send_probe(6'd63, 1'b1, 24'd100001);
    send_probe(6'd42, 1'b1, 24'd499999);
    send_probe(6'd42, 1'b1, 24'd500001);       // average into critical
    send_probe(6'd42, 1'b1, 24'd1000000);
    for (int i = 0; i < 20; i++) send_probe(6'd21, 1'b1, 24'd500);
    send_probe(6'd21, 1'b0, 24'd0);            // loss just under 5 percent
    send_probe(6'd21, 1'b1, 24'd700);
  endtask

  // every register, the extremes among the values, unmapped indexes
  task automatic test_registers();
    write_reg(3'd5, 24'hFFFFFF);
    write_reg(3'd7, 24'h000001);
    write_reg(llhm_pkg::REG_FAIL_LIM, 24'h000000);   // zero limit: always critical
    send_probe(6'd9, 1'b1, 24'd10);
    send_probe(6'd9, 1'b1, 24'd20);
    write_reg(llhm_pkg::REG_FAIL_LIM, 24'hFFFFFF);   // masked to 255
    write_reg(llhm_pkg::REG_LOSS_WARN, 24'hFFFF7F);  // 127: never reached
    write_reg(llhm_pkg::REG_LOSS_CRIT, 24'h00007F);
    write_reg(llhm_pkg::REG_LAT_WARN, 24'd0);        // every average warns
    write_reg(llhm_pkg::REG_LAT_CRIT, 24'hFFFFFF);
    for (int i = 0; i < 6; i++) send_probe(6'd10, 1'(i % 3 != 0), rand_latency());
    write_reg(llhm_pkg::REG_LOSS_WARN, 24'd0);       // loss warning always holds
    write_reg(llhm_pkg::REG_LOSS_CRIT, 24'd100);     // critical only at all lost
    send_probe(6'd11, 1'b0, 24'd0);
    send_probe(6'd11, 1'b1, 24'd3);
    write_reg(llhm_pkg::REG_LAT_CRIT, 24'd0);
    write_reg(llhm_pkg::REG_LOSS_WARN, 24'(llhm_pkg::RST_LOSS_WARN));
    write_reg(llhm_pkg::REG_LOSS_CRIT, 24'(llhm_pkg::RST_LOSS_CRIT));
    send_probe(6'd12, 1'b1, 24'd5);
    write_reg(llhm_pkg::REG_LAT_WARN, llhm_pkg::RST_LAT_WARN);
    write_reg(llhm_pkg::REG_LAT_CRIT, llhm_pkg::RST_LAT_CRIT);
    write_reg(llhm_pkg::REG_FAIL_LIM, 24'(llhm_pkg::RST_FAIL_LIM));
  endtask

  // one server past a full window so old samples leave the sum
  task automatic test_window_wrap();
    logic [5:0] s;
    s = 6'($urandom_range(1, 62));
    for (int i = 0; i < WIN + 40; i++) begin
      send_probe(s, 1'($urandom_range(9) != 0),
                 (i < WIN / 2) ? 24'($urandom_range(0, 300000)) : rand_latency());
    end
  endtask

  // random probes across servers, thresholds changed between phases
  task automatic test_random(int unsigned count);
    logic [5:0] s;
    write_reg(llhm_pkg::REG_LAT_WARN,  24'($urandom_range(0, 400000)));
    write_reg(llhm_pkg::REG_LAT_CRIT,  24'($urandom_range(200000, 800000)));
    write_reg(llhm_pkg::REG_LOSS_WARN, 24'($urandom_range(0, 30)));
    write_reg(llhm_pkg::REG_LOSS_CRIT, 24'($urandom_range(10, 100)));
    write_reg(llhm_pkg::REG_FAIL_LIM,  24'($urandom_range(1, 6)));
    for (int i = 0; i < count; i++) begin
      // mostly a handful of busy servers so records build up
      s = ($urandom_range(3) != 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
      send_probe(s, 1'($urandom_range(3) != 0), rand_latency());
    end
  endtask

  // receiver holds off long while probes keep coming, so the input stalls
  task automatic test_backpressure();
    wait_quiet();
    hold_off = 400;
    for (int i = 0; i < 12; i++) send_probe(6'($urandom), 1'($urandom), rand_latency());
    wait_quiet();
  endtask

  initial begin
    clear_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 36; rx_idle_pct = 77;
    test_directed();
    test_registers();
    test_random(30);
    test_backpressure();

    tx_idle_pct = 77; rx_idle_pct = 36;
    test_random(30);
    test_backpressure();

    tx_idle_pct = 0; rx_idle_pct = 0;
    test_window_wrap();
    test_random(30);
    write_reg(llhm_pkg::REG_FAIL_LIM, 24'd255);
    test_random(10);

    wait_quiet();
    $display("covered %0d probes, %0d results, %0d register writes, %0d window wraps",
             probes_sent, results_seen, reg_writes, wraps_seen);
    $display("health grades seen: ok %0d, warning %0d, critical %0d",
             health_hits[llhm_pkg::HEALTH_OK], health_hits[llhm_pkg::HEALTH_WARN],
             health_hits[llhm_pkg::HEALTH_CRIT]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/llhm_pkg.sv
hw/rtl/llhm_ram.sv
hw/rtl/llhm_div.sv
hw/rtl/link_latency_health_monitor_top.sv
sim/link_latency_health_monitor_top_test.sv
